>>> design/ordered_set_engine_defines.svh
// Assertion macros for the ordered set engine checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ORDERED_SET_ENGINE_DEFINES_SVH
`define ORDERED_SET_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ose_pkg.sv
// Shared types and constants for the ordered set engine.
// No dependencies; used by ose_cell and ordered_set_engine.
package ose_pkg;

   localparam int KEY_W            = 32;
   localparam int OP_W             = 3;
   localparam int DEFAULT_CAPACITY = 256;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 3'd0,
      OP_ERASE    = 3'd1,
      OP_CONTAINS = 3'd2,
      OP_SUCC     = 3'd3,
      OP_PRED     = 3'd4
   } op_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   // Broadcast from the controller to every cell of the row
   typedef struct packed {
      logic                    capture; // latch compare flags against key
      logic                    update;  // apply the shift for this request
      logic                    ins;     // open a slot at the lower bound
      logic                    era;     // close the slot at the lower bound
      logic                    succ;    // drive the successor key out
      logic                    pred;    // drive the predecessor key out
      logic signed [KEY_W-1:0] key;     // probe key, or key to insert
   } cell_cmd_type;

   // Per-cell status seen by the controller
   typedef struct packed {
      logic eq;       // cell holds the request key
      logic succ_hit; // cell is occupied and greater than the request key
   } cell_stat_type;

endpackage

>>> design/ose_cell.sv
// One slot of the sorted row: holds a key and its compare flags.
// Depends on ose_pkg; instantiated CAPACITY times by ordered_set_engine.
module ose_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 9
) (
   input  logic                           clock,
   input  ose_pkg::cell_cmd_type          cmd,
   input  logic [CNT_W-1:0]               count,
   input  logic                           left_lt,
   input  logic                           left_le,
   input  logic signed [ose_pkg::KEY_W-1:0] left_key,
   input  logic                           right_lt,
   input  logic signed [ose_pkg::KEY_W-1:0] right_key,
   output logic signed [ose_pkg::KEY_W-1:0] key_out,
   output logic                           lt_out,
   output logic                           le_out,
   output ose_pkg::cell_stat_type         stat,
   output logic signed [ose_pkg::KEY_W-1:0] sel_key
);

   logic signed [ose_pkg::KEY_W-1:0] key_ff, key_in;
   logic                             lt_ff, lt_in;
   logic                             le_ff, le_in;
   logic                             occupied;
   logic                             sel;

   assign occupied = count > CNT_W'(INDEX);

   // Compare against the probe key when a request is taken, hold otherwise
   always_comb begin
      lt_in = lt_ff;
      le_in = le_ff;
      if (cmd.capture) begin
         lt_in = occupied && (key_ff <  cmd.key);
         le_in = occupied && (key_ff <= cmd.key);
      end
   end

   // Shift right on insert, left on erase, from the lower bound upward
   always_comb begin
      key_in = key_ff;
      if (cmd.update && !lt_ff) begin
         priority if (cmd.ins) begin
            key_in = left_lt ? cmd.key : left_key;
         end else if (cmd.era) begin
            key_in = right_key;
         end else begin
            key_in = key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      le_ff  <= le_in;
   end

   // Drive this key out when it is the requested neighbour of the probe
   always_comb begin
      sel = (cmd.succ && occupied && !le_ff && left_le) ||
            (cmd.pred && lt_ff && !right_lt);
      sel_key = sel ? key_ff : '0;
   end

   assign stat.eq       = le_ff && !lt_ff;
   assign stat.succ_hit = occupied && !le_ff;
   assign key_out       = key_ff;
   assign lt_out        = lt_ff;
   assign le_out        = le_ff;

endmodule

>>> design/ordered_set_engine.sv
// A taken request moves the controller to ST_UPDATE, from which the result strobe is registered.
// The block takes no new request while busy; a compare step latches flags in every cell and the
// update step shifts the cells from the lower bound one place on insert or erase and collects the answer.
// Reset clears the key count and the result strobe; stored keys need no clearing pass.
// The receiver cannot stall, so results leave on their strobe cycle.
// Top level of the ordered set engine; depends on ose_pkg and ose_cell.
module ordered_set_engine #(
   parameter int CAPACITY = ose_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ose_pkg::OP_W-1:0]         req_op,
   input  logic signed [ose_pkg::KEY_W-1:0] req_key,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic signed [ose_pkg::KEY_W-1:0] rsp_value,
   output logic                             rsp_full_res
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   ose_pkg::state_type               state_ff, state_in;
   logic [ose_pkg::OP_W-1:0]         op_ff, op_in;
   logic signed [ose_pkg::KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic signed [ose_pkg::KEY_W-1:0] rsp_value_ff, rsp_value_in;
   logic                             rsp_full_ff, rsp_full_in;

   ose_pkg::cell_cmd_type            cmd;
   logic                             accept;
   logic                             present;
   logic                             succ_any;
   logic                             table_full;
   logic [CAPACITY-1:0]              lt_vec, le_vec, eq_vec, succ_vec;
   logic signed [ose_pkg::KEY_W-1:0] key_vec [CAPACITY];
   logic signed [ose_pkg::KEY_W-1:0] sel_vec [CAPACITY];
   ose_pkg::cell_stat_type           stat_vec [CAPACITY];
   logic signed [ose_pkg::KEY_W-1:0] sel_or;

   assign busy   = (state_ff == ose_pkg::ST_UPDATE);
   assign accept = start && !busy;

   // Row of cells, each wired to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                             l_lt, l_le, r_lt;
      logic signed [ose_pkg::KEY_W-1:0] l_key, r_key;

      if (i == 0) begin : g_head
         assign l_lt  = 1'b1;
         assign l_le  = 1'b1;
         assign l_key = '0;
      end else begin : g_mid
         assign l_lt  = lt_vec[i-1];
         assign l_le  = le_vec[i-1];
         assign l_key = key_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign r_lt  = 1'b0;
         assign r_key = '0;
      end else begin : g_body
         assign r_lt  = lt_vec[i+1];
         assign r_key = key_vec[i+1];
      end

      ose_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .count     (count_ff),
         .left_lt   (l_lt),
         .left_le   (l_le),
         .left_key  (l_key),
         .right_lt  (r_lt),
         .right_key (r_key),
         .key_out   (key_vec[i]),
         .lt_out    (lt_vec[i]),
         .le_out    (le_vec[i]),
         .stat      (stat_vec[i]),
         .sel_key   (sel_vec[i])
      );

      assign eq_vec[i]   = stat_vec[i].eq;
      assign succ_vec[i] = stat_vec[i].succ_hit;
   end

   // Merge the one-hot key selections of the row
   always_comb begin
      sel_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_or = sel_or | sel_vec[i];
      end
   end

   assign present    = |eq_vec;
   assign succ_any   = |succ_vec;
   assign table_full = (count_ff == CNT_W'(CAPACITY));

   // Broadcast command to the cells
   always_comb begin
      cmd.capture = accept;
      cmd.update  = busy;
      cmd.ins     = (op_ff == ose_pkg::OP_INSERT) && !present && !table_full;
      cmd.era     = (op_ff == ose_pkg::OP_ERASE) && present;
      cmd.succ    = (op_ff == ose_pkg::OP_SUCC);
      cmd.pred    = (op_ff == ose_pkg::OP_PRED);
      cmd.key     = busy ? key_ff : req_key;
   end

   // Next state, request capture, count and result
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_full_in  = rsp_full_ff;

      unique case (state_ff)
         ose_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               key_in   = req_key;
               state_in = ose_pkg::ST_UPDATE;
            end
         end
         ose_pkg::ST_UPDATE: begin
            state_in     = ose_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_found_in = 1'b0;
            rsp_value_in = sel_or;
            rsp_full_in  = 1'b0;
            unique case (op_ff)
               ose_pkg::OP_INSERT: begin
                  rsp_found_in = present;
                  rsp_full_in  = !present && table_full;
                  if (cmd.ins) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               ose_pkg::OP_ERASE: begin
                  rsp_found_in = present;
                  if (cmd.era) begin
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               ose_pkg::OP_CONTAINS: rsp_found_in = present;
               ose_pkg::OP_SUCC:     rsp_found_in = succ_any;
               ose_pkg::OP_PRED:     rsp_found_in = lt_vec[0];
               default:              rsp_found_in = 1'b0;
            endcase
         end
         default: state_in = ose_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ose_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_full_res = rsp_full_ff;

endmodule

>>> design/ose_checker.sv
// Port-level checks for the ordered set engine, bound to its top level.
// Depends on ose_pkg and ordered_set_engine_defines.svh.
`include "ordered_set_engine_defines.svh"

module ose_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic                             rsp_found,
   input logic signed [ose_pkg::KEY_W-1:0] rsp_value,
   input logic                             rsp_full_res
);

   // A taken request yields its result strobe by way of the update state
   `OSE_ASSERT_IMPLY(a_rsp_timing, clock, reset, start && !busy, ##2 rsp_valid, "missing result")
   // The engine is free again while a result is shown
   `OSE_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy, "busy during result")
   // Results never come in adjacent cycles
   `OSE_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid, !rsp_valid, "back-to-back results")
   // A refused insert never reports the key as present
   `OSE_ASSERT_IMPLY(a_full_excl, clock, reset, rsp_valid && rsp_full_res, !rsp_found,
      "full with found")
   // No answer means a zero value
   `OSE_ASSERT_IMPLY(a_zero_value, clock, reset, rsp_valid && !rsp_found, rsp_value == '0,
      "value without found")

endmodule

bind ordered_set_engine ose_checker u_ose_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_found    (rsp_found),
   .rsp_value    (rsp_value),
   .rsp_full_res (rsp_full_res)
);

>>> bench/ordered_set_engine_test.sv
// Self-checking bench for ordered_set_engine: directed and random requests against a sorted-queue
// predictor, with results checked field by field. Depends on ose_pkg and the ordered_set_engine RTL.
module ordered_set_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 10;
   localparam int CAPACITY       = ose_pkg::DEFAULT_CAPACITY;
   localparam int MAX_GAP        = 30;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_CYCLES   = 10;

   localparam logic signed [ose_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [ose_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic                             found;
      logic signed [ose_pkg::KEY_W-1:0] value;
      logic                             full_res;
   } set_answer_type;

   // Sorted copy of the stored set plus the answers still owed by the block
   class set_scoreboard;
      logic signed [ose_pkg::KEY_W-1:0] stored_keys[$];
      set_answer_type                   pending_answers[$];
      int                               mismatches = 0;

      // Apply one accepted request to the set and queue the answer it owes
      function void note_request(logic [ose_pkg::OP_W-1:0] op,
                                 logic signed [ose_pkg::KEY_W-1:0] key);
         set_answer_type ans;
         int             lower;
         int             upper;
         int             count;
         logic           present;
         count = stored_keys.size();
         lower = 0;
         while (lower < count && stored_keys[lower] < key) lower++;
         upper = lower;
         while (upper < count && stored_keys[upper] <= key) upper++;
         present = (lower < count) && (stored_keys[lower] == key);
         ans.found    = 1'b0;
         ans.value    = '0;
         ans.full_res = 1'b0;
         case (op)
            ose_pkg::OP_INSERT: begin
               if (present) ans.found = 1'b1;
               else if (count >= CAPACITY) ans.full_res = 1'b1;
               else stored_keys.insert(lower, key);
            end
            ose_pkg::OP_ERASE: begin
               if (present) begin
                  ans.found = 1'b1;
                  stored_keys.delete(lower);
               end
            end
            ose_pkg::OP_CONTAINS: ans.found = present;
            ose_pkg::OP_SUCC: begin
               if (upper < count) begin
                  ans.found = 1'b1;
                  ans.value = stored_keys[upper];
               end
            end
            ose_pkg::OP_PRED: begin
               if (lower > 0) begin
                  ans.found = 1'b1;
                  ans.value = stored_keys[lower-1];
               end
            end
            default: ;
         endcase
         pending_answers.push_back(ans);
      endfunction

      // Compare one strobed result with the oldest owed answer
      function void check_answer(logic found, logic signed [ose_pkg::KEY_W-1:0] value,
                                 logic full_res);
         set_answer_type want;
         if (pending_answers.size() == 0) begin
            $error("result strobe with no request outstanding");
            mismatches++;
            return;
         end
         want = pending_answers.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            mismatches++;
         end
         if (full_res !== want.full_res) begin
            $error("full_res: expected %0b, got %0b", want.full_res, full_res);
            mismatches++;
         end
      endfunction
   endclass

   logic                             clock   = 1'b0;
   logic                             reset   = 1'b1;
   logic                             start   = 1'b0;
   logic                             busy;
   logic [ose_pkg::OP_W-1:0]         req_op  = '0;
   logic signed [ose_pkg::KEY_W-1:0] req_key = '0;
   logic                             rsp_valid;
   logic                             rsp_found;
   logic signed [ose_pkg::KEY_W-1:0] rsp_value;
   logic                             rsp_full_res;

   set_scoreboard tracker = new;

   ordered_set_engine #(.CAPACITY(CAPACITY)) DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_found    (rsp_found),
      .rsp_value    (rsp_value),
      .rsp_full_res (rsp_full_res)
   );

   always #(CLOCK_PERIOD/2) clock = ~clock;

   // Check results first, then note the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_answer(rsp_found, rsp_value, rsp_full_res);
         if (start && !busy) tracker.note_request(req_op, req_key);
      end
   end

   // Abort when neither channel moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("ordered_set_engine_test: FAIL");
      $finish;
   end

   // Idle for a random gap, then hold the request until the block takes it
   task automatic issue(logic [ose_pkg::OP_W-1:0] op, logic signed [ose_pkg::KEY_W-1:0] key,
                        int unsigned idle_pct);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_op  <= op;
      req_key <= key;
      start   <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Stored keys at present_pct, some neighbours and extremes, the rest anywhere
   function automatic logic signed [ose_pkg::KEY_W-1:0] pick_key(int unsigned present_pct);
      int unsigned roll;
      int          count;
      roll  = $urandom_range(99);
      count = tracker.stored_keys.size();
      if (count != 0 && roll < present_pct)
         return tracker.stored_keys[$urandom_range(count-1)];
      if (count != 0 && roll < present_pct + 15)
         return tracker.stored_keys[$urandom_range(count-1)] +
                ($urandom_range(1) ? 32'sd1 : -32'sd1);
      if (roll < present_pct + 30) begin
         case ($urandom_range(3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic random_request(int unsigned ins_pct, int unsigned era_pct,
                                 int unsigned present_pct, int unsigned idle_pct);
      int unsigned              roll;
      logic [ose_pkg::OP_W-1:0] op;
      roll = $urandom_range(99);
      if (roll < ins_pct) op = ose_pkg::OP_INSERT;
      else if (roll < ins_pct + era_pct) op = ose_pkg::OP_ERASE;
      else begin
         roll = $urandom_range(19);
         if (roll == 0) op = ose_pkg::OP_W'(ose_pkg::OP_PRED + 1 + $urandom_range(2));
         else begin
            case (roll % 3)
               0: op = ose_pkg::OP_CONTAINS;
               1: op = ose_pkg::OP_SUCC;
               default: op = ose_pkg::OP_PRED;
            endcase
         end
      end
      issue(op, pick_key(present_pct), idle_pct);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty set: every query misses
      issue(ose_pkg::OP_CONTAINS, '0, 0);
      issue(ose_pkg::OP_SUCC, '0, 0);
      issue(ose_pkg::OP_PRED, '0, 0);
      issue(ose_pkg::OP_ERASE, 32'sd5, 0);
      // Extremes, then a duplicate insert
      issue(ose_pkg::OP_INSERT, KEY_MIN, 0);
      issue(ose_pkg::OP_INSERT, KEY_MAX, 0);
      issue(ose_pkg::OP_INSERT, '0, 0);
      issue(ose_pkg::OP_INSERT, '1, 0);
      issue(ose_pkg::OP_INSERT, '0, 0);
      issue(ose_pkg::OP_CONTAINS, KEY_MIN, 0);
      issue(ose_pkg::OP_CONTAINS, 32'sd1, 0);
      // No neighbour beyond either end, then hits across the sign boundary
      issue(ose_pkg::OP_SUCC, KEY_MAX, 0);
      issue(ose_pkg::OP_PRED, KEY_MIN, 0);
      issue(ose_pkg::OP_SUCC, KEY_MIN, 0);
      issue(ose_pkg::OP_PRED, KEY_MAX, 0);
      issue(ose_pkg::OP_SUCC, '1, 0);
      issue(ose_pkg::OP_PRED, '0, 0);
      issue(ose_pkg::OP_SUCC, 32'sd100, 0);
      issue(ose_pkg::OP_PRED, -32'sd100, 0);
      // Erase a present key, then the same key again
      issue(ose_pkg::OP_ERASE, '0, 0);
      issue(ose_pkg::OP_ERASE, '0, 0);
      // Unused codes leave the set alone
      for (int code = ose_pkg::OP_PRED + 1; code < 2**ose_pkg::OP_W; code++)
         issue(ose_pkg::OP_W'(code), KEY_MIN, 0);
      issue(ose_pkg::OP_CONTAINS, KEY_MAX, 0);

      // Mixed traffic, back to back
      repeat (30) random_request(35, 20, 40, 0);
      // Fill to capacity with a sparse sender, then hit the full table
      while (tracker.stored_keys.size() < CAPACITY) random_request(95, 0, 0, 88);
      repeat (20) random_request(70, 8, 30, 88);
      // Drain with moderate gaps
      repeat (40) random_request(15, 55, 50, 31);
      // Finish with mixed traffic and no gaps
      repeat (25) random_request(35, 25, 40, 0);

      start <= 1'b0;
      while (tracker.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0)
         $display("ordered_set_engine_test: PASS");
      else
         $display("ordered_set_engine_test: FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/ose_pkg.sv
design/ose_cell.sv
design/ordered_set_engine.sv
design/ose_checker.sv
bench/ordered_set_engine_test.sv
